FILE: sv/blh_pkg.sv
// shared constants, request codes and structs for the burst length histogram
package blh_pkg;

  localparam int NUM_BINS    = 64;
  localparam int BIN_W       = $clog2(NUM_BINS);
  localparam int COUNT_W     = 32;
  localparam int TIME_W      = 32;
  localparam int REQ_W       = 2;

  localparam logic [TIME_W-1:0] GAP_THRESHOLD_RESET = TIME_W'(50);
  localparam logic [BIN_W-1:0]  LAST_BIN            = BIN_W'(NUM_BINS - 1);
  localparam logic [COUNT_W-1:0] COUNT_MAX          = {COUNT_W{1'b1}};

  localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FLUSH  = 2'd2;

  // histogram access issued with a request
  typedef struct packed {
    logic             rd;
    logic             inc;
    logic [BIN_W-1:0] addr;
  } hist_op_t;

  // per-request fields settled by the control stage
  typedef struct packed {
    logic             burst_closed;
    logic [BIN_W-1:0] closed_length;
    logic [BIN_W-1:0] longest_burst;
    logic [BIN_W-1:0] open_length;
    logic             length_overflow;
  } ctrl_res_t;

endpackage

FILE: sv/blh_ctrl.sv
// burst tracking: gap compare, run length, longest burst and overflow flag
module blh_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [blh_pkg::TIME_W-1:0]    cfg_wdata,
  input  logic                          accept,
  input  logic [blh_pkg::REQ_W-1:0]     req_type,
  input  logic [blh_pkg::TIME_W-1:0]    sample_time,
  input  logic                          spike_flag,
  input  logic [blh_pkg::BIN_W-1:0]     bin_index,
  output blh_pkg::hist_op_t             op,
  output blh_pkg::ctrl_res_t            res
);

  logic [blh_pkg::TIME_W-1:0] gap_threshold;
  logic [blh_pkg::TIME_W-1:0] last_spike_stamp;
  logic [blh_pkg::BIN_W-1:0]  run_length;
  logic [blh_pkg::BIN_W-1:0]  longest_seen;
  logic                       overflow_seen;

  logic [blh_pkg::BIN_W-1:0]  run_length_next;
  logic [blh_pkg::BIN_W-1:0]  longest_seen_next;
  logic                       overflow_seen_next;
  logic [blh_pkg::TIME_W-1:0] gap;
  logic                       is_spike;
  logic                       is_flush;
  logic                       open;
  logic                       close;

  assign is_spike = (req_type == blh_pkg::REQ_SAMPLE) && spike_flag;
  assign is_flush = (req_type == blh_pkg::REQ_FLUSH);
  assign open     = (run_length != '0);
  // wraps modulo the stamp width
  assign gap      = sample_time - last_spike_stamp;
  assign close    = open && ((is_spike && (gap > gap_threshold)) || is_flush);

  always_comb begin
    run_length_next    = run_length;
    overflow_seen_next = overflow_seen;
    longest_seen_next  = longest_seen;
    if (is_spike) begin
      if (!open || close) begin
        run_length_next = blh_pkg::BIN_W'(1);
      end else if (run_length >= blh_pkg::LAST_BIN) begin
        run_length_next    = blh_pkg::LAST_BIN;
        overflow_seen_next = 1'b1;
      end else begin
        run_length_next = run_length + blh_pkg::BIN_W'(1);
      end
    end else if (close) begin
      run_length_next = '0;
    end
    if (close && (run_length > longest_seen)) begin
      longest_seen_next = run_length;
    end
  end

  always_comb begin
    op.rd   = (req_type == blh_pkg::REQ_READ);
    op.inc  = close;
    op.addr = close ? run_length : bin_index;

    res.burst_closed    = close;
    res.closed_length   = close ? run_length : '0;
    res.longest_burst   = longest_seen_next;
    res.open_length     = run_length_next;
    res.length_overflow = overflow_seen_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_threshold    <= blh_pkg::GAP_THRESHOLD_RESET;
      last_spike_stamp <= '0;
      run_length       <= '0;
      longest_seen     <= '0;
      overflow_seen    <= 1'b0;
    end else begin
      if (cfg_we) begin
        gap_threshold <= cfg_wdata;
      end
      if (accept) begin
        run_length    <= run_length_next;
        longest_seen  <= longest_seen_next;
        overflow_seen <= overflow_seen_next;
        if (is_spike) begin
          last_spike_stamp <= sample_time;
        end
      end
    end
  end

endmodule

FILE: sv/blh_hist.sv
// histogram memory: registered read, saturating increment, write-back forwarding
module blh_hist (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  blh_pkg::hist_op_t             op,
  input  logic                          s1_go,
  output logic [blh_pkg::COUNT_W-1:0]   count
);

  logic [blh_pkg::COUNT_W-1:0] mem [blh_pkg::NUM_BINS];
  logic [blh_pkg::NUM_BINS-1:0] bin_valid;

  blh_pkg::hist_op_t            s1_op;
  logic [blh_pkg::COUNT_W-1:0]  rd_data;
  logic                         rd_hit;

  logic                         fwd_valid;
  logic [blh_pkg::BIN_W-1:0]    fwd_addr;
  logic [blh_pkg::COUNT_W-1:0]  fwd_data;

  logic [blh_pkg::COUNT_W-1:0]  base;
  logic [blh_pkg::COUNT_W-1:0]  inc_val;
  logic                         wr_en;

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= mem[op.addr];
      rd_hit  <= bin_valid[op.addr];
      s1_op   <= op;
    end
  end

  // last write-back covers a read issued on the same edge
  always_comb begin
    if (fwd_valid && (fwd_addr == s1_op.addr)) begin
      base = fwd_data;
    end else if (rd_hit) begin
      base = rd_data;
    end else begin
      base = '0;
    end
    inc_val = (base == blh_pkg::COUNT_MAX) ? base : base + blh_pkg::COUNT_W'(1);
    if (s1_op.inc) begin
      count = inc_val;
    end else if (s1_op.rd) begin
      count = base;
    end else begin
      count = '0;
    end
  end

  assign wr_en = s1_go && s1_op.inc;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_op.addr] <= inc_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_valid <= '0;
      fwd_valid <= 1'b0;
    end else if (wr_en) begin
      bin_valid[s1_op.addr] <= 1'b1;
      fwd_valid             <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_addr <= s1_op.addr;
      fwd_data <= inc_val;
    end
  end

endmodule

FILE: sv/burst_length_histogram.sv
// burst length histogram of a spike train, top level with output register
// pipeline: an accepted request is held in the first stage with its memory read, and
// moves on to the output register once that register is free
// throughput: one request per cycle; the memory is read on accept and written back when
// the request leaves the first stage, with the last write forwarded to the next read;
// input stalls only while both stages hold requests and m_tready is low
// reset: rst clears run state, longest burst, overflow flag and all bin valid
// bits at once, so the histogram reads as zero; the gap threshold returns to 50
module burst_length_histogram (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // sample_time[31:0], spike_flag[32], bin_index[38:33]
  input  logic [1:0]  s_tuser,  // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,  // closed_length[5:0], bin_count[37:6], longest_burst[43:38],
                                // open_length[49:44], length_overflow[50]
  output logic        m_tuser   // burst_closed
);

  blh_pkg::hist_op_t             op;
  blh_pkg::ctrl_res_t            ctrl_res;
  blh_pkg::ctrl_res_t            s1_res;
  blh_pkg::ctrl_res_t            out_res;
  logic [blh_pkg::COUNT_W-1:0]   count;
  logic [blh_pkg::COUNT_W-1:0]   out_count;
  logic                          s1_valid;
  logic                          out_go;
  logic                          s1_go;
  logic                          accept;

  assign out_go   = !m_tvalid || m_tready;
  assign s1_go    = s1_valid && out_go;
  assign s_tready = !s1_valid || out_go;
  assign accept   = s_tvalid && s_tready;

  blh_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .accept      (accept),
    .req_type    (s_tuser),
    .sample_time (s_tdata[31:0]),
    .spike_flag  (s_tdata[32]),
    .bin_index   (s_tdata[38:33]),
    .op          (op),
    .res         (ctrl_res)
  );

  blh_hist u_hist (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .op     (op),
    .s1_go  (s1_go),
    .count  (count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) begin
        s1_valid <= s_tvalid;
      end
      if (out_go) begin
        m_tvalid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res <= ctrl_res;
    end
    if (s1_go) begin
      out_res   <= s1_res;
      out_count <= count;
    end
  end

  assign m_tuser = out_res.burst_closed;
  assign m_tdata = {5'd0, out_res.length_overflow, out_res.open_length,
                    out_res.longest_burst, out_count, out_res.closed_length};

endmodule
